/* rtl/mcts_pkg.sv */
// Shared types, codes, timing constants and melody tables of the tone sequencer.
package mcts_pkg;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] button_number;
      logic       manual_hold;
   } mcts_req_type;

   typedef struct packed {
      logic [7:0] pwm_period;
      logic [7:0] pwm_compare;
      logic       cue_playing;
   } mcts_rsp_type;

   localparam int ButtonDividerDefault = 30;
   localparam int MelodyStepsDefault   = 8;

   // request opcodes
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_BUTTON  = 2'd1;
   localparam logic [1:0] OP_BEEP    = 2'd2;
   localparam logic [1:0] OP_RESTART = 2'd3;

   // note codes
   localparam logic [2:0] NOTE_C4      = 3'd0;
   localparam logic [2:0] NOTE_DSHARP4 = 3'd1;
   localparam logic [2:0] NOTE_G4      = 3'd2;
   localparam logic [2:0] NOTE_C5      = 3'd3;
   localparam logic [2:0] NOTE_B3      = 3'd4;

   // button numbers with a note of their own
   localparam logic [2:0] BTN_C5  = 3'd1;
   localparam logic [2:0] BTN_G4  = 3'd2;
   localparam logic [2:0] BTN_DS4 = 3'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_AUDIO_MODE  = 3'd0;
   localparam logic [2:0] CSR_PERIOD_C4   = 3'd1;
   localparam logic [2:0] CSR_PERIOD_DS4  = 3'd2;
   localparam logic [2:0] CSR_PERIOD_G4   = 3'd3;
   localparam logic [2:0] CSR_PERIOD_C5   = 3'd4;
   localparam logic [2:0] CSR_PERIOD_B3   = 3'd5;

   // audio modes
   localparam logic [1:0] MODE_SILENT = 2'd0;
   localparam logic [1:0] MODE_NORMAL = 2'd1;
   localparam logic [1:0] MODE_SOFT   = 2'd2;

   // reset values of the configuration registers
   localparam logic [7:0] RST_PERIOD_C4  = 8'd236;
   localparam logic [7:0] RST_PERIOD_DS4 = 8'd198;
   localparam logic [7:0] RST_PERIOD_G4  = 8'd157;
   localparam logic [7:0] RST_PERIOD_C5  = 8'd118;
   localparam logic [7:0] RST_PERIOD_B3  = 8'd250;

   // durations in ms
   localparam logic [8:0] NOTE_TIME  = 9'd220;
   localparam logic [8:0] NOTE_GAP   = 9'd90;
   localparam logic [8:0] LOOP_GAP   = 9'd160;
   localparam logic [7:0] PRESS_TIME = 8'd200;
   localparam logic [7:0] BEEP_TIME  = 8'd160;

   // volume divisors and their reciprocal scaling
   localparam int SoftDiv    = 90;
   localparam int NormalDiv  = 60;
   localparam int RecipShift = 16;
   localparam int RecipW     = RecipShift + 1;

   localparam logic [2:0] LAST_STEP = 3'd7;

   function automatic logic [8:0] mel_len(input logic [2:0] step);
      logic [8:0] len;
      if (step == LAST_STEP) begin
         len = LOOP_GAP;
      end else if (step[0]) begin
         len = NOTE_GAP;
      end else begin
         len = NOTE_TIME;
      end
      return len;
   endfunction

   function automatic logic mel_is_tone(input logic [2:0] step);
      return ~step[0];
   endfunction

   function automatic logic [2:0] mel_note(input logic [2:0] step);
      logic [2:0] note;
      unique case (step[2:1])
         2'd0:    note = NOTE_C4;
         2'd1:    note = NOTE_G4;
         2'd2:    note = NOTE_DSHARP4;
         default: note = NOTE_G4;
      endcase
      return note;
   endfunction

endpackage

/* rtl/melody_and_cue_tone_sequencer.sv */
// Melody and cue tone sequencer: top level with state update and response buffer.
//
//   channel | ports                      | direction | carries
//   --------+----------------------------+-----------+-------------------------------
//   req     | req_valid/ready, req_data  | in        | tick, cue start, restart
//   rsp     | rsp_valid/ready, rsp_data  | out       | PWM period, compare, cue flag
//   csr     | csr_valid/ready, csr_index,| in        | audio mode and note periods
//           | csr_data                   |           |
//
// Each request is processed in the cycle it is accepted: one pass of logic from the
// state registers through one reciprocal multiply into the response buffer.
// A new request can be taken every cycle while the buffer has room; rsp_valid is set in the cycle after.
// Reset is synchronous; it restores the state and configuration defaults and
// empties the two-entry response buffer. No clearing pass is needed.
// When both buffer entries wait on rsp_ready, req_ready drops until one is taken.
module melody_and_cue_tone_sequencer
   import mcts_pkg::*;
#(
   parameter int BUTTON_DIVIDER = ButtonDividerDefault,
   parameter int MELODY_STEPS   = MelodyStepsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  mcts_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output mcts_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [7:0]   csr_data
);

   // Reciprocals for constant division of an 8-bit period: q = (p * M) >> 16.
   localparam logic [RecipW-1:0] RecipButton =
      RecipW'((2**RecipShift + BUTTON_DIVIDER - 1) / BUTTON_DIVIDER);
   localparam logic [RecipW-1:0] RecipSoft   =
      RecipW'((2**RecipShift + SoftDiv - 1) / SoftDiv);
   localparam logic [RecipW-1:0] RecipNormal =
      RecipW'((2**RecipShift + NormalDiv - 1) / NormalDiv);
   localparam logic [3:0] StepsCount = 4'(MELODY_STEPS);

   // configuration
   logic [1:0] audio_mode_ff;
   logic [7:0] period_c4_ff, period_ds4_ff, period_g4_ff, period_c5_ff, period_b3_ff;

   // sequencer state
   logic [2:0] mel_next_ff,  mel_next_in;
   logic [2:0] mel_cur_ff,   mel_cur_in;
   logic [8:0] mel_left_ff,  mel_left_in;
   logic       mel_valid_ff, mel_valid_in;
   logic       cue_active_ff, cue_active_in;
   logic [2:0] cue_note_ff,  cue_note_in;
   logic       cue_started_ff, cue_started_in;
   logic [7:0] cue_step_ff,  cue_step_in;
   logic [7:0] cue_total_ff, cue_total_in;
   logic [7:0] period_ff,    period_in;
   logic [7:0] compare_ff,   compare_in;

   // response buffer
   mcts_rsp_type head_ff, tail_ff;
   logic [1:0]   count_ff;

   logic req_fire, rsp_fire;
   logic tone_en, tone_cue, rest_en;
   logic [2:0] tone_note;
   logic [7:0] tone_period;
   logic [RecipW-1:0] recip;
   logic [RecipW+7:0] product;
   logic [7:0] quotient;
   mcts_rsp_type result;

   assign req_ready = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = head_ff;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // Next state for the accepted request; tone writes collapse into one writer.
   always_comb begin
      logic       audible;
      logic       stop;
      logic [2:0] step;
      mel_next_in    = mel_next_ff;
      mel_cur_in     = mel_cur_ff;
      mel_left_in    = mel_left_ff;
      mel_valid_in   = mel_valid_ff;
      cue_active_in  = cue_active_ff;
      cue_note_in    = cue_note_ff;
      cue_started_in = cue_started_ff;
      cue_step_in    = cue_step_ff;
      cue_total_in   = cue_total_ff;
      tone_en        = 1'b0;
      tone_cue       = 1'b0;
      tone_note      = NOTE_C4;
      rest_en        = 1'b0;
      audible        = ~cue_active_ff;
      stop           = 1'b0;
      step           = mel_next_ff;
      unique case (req_data.opcode)
         OP_TICK: begin
            if (!req_data.manual_hold) begin
               // advance the melody one ms, silently while a cue owns the speaker
               if (mel_left_ff != 9'd0) begin
                  mel_left_in = mel_left_ff - 9'd1;
               end else if (audio_mode_ff == MODE_SILENT) begin
                  rest_en      = audible;
                  mel_valid_in = 1'b0;
                  mel_left_in  = 9'd1;
               end else begin
                  if ({1'b0, mel_next_ff} >= StepsCount) begin
                     step = 3'd0;
                  end
                  mel_cur_in   = step;
                  mel_valid_in = 1'b1;
                  mel_left_in  = mel_len(step);
                  if (audible) begin
                     if (mel_is_tone(step)) begin
                        tone_en   = 1'b1;
                        tone_note = mel_note(step);
                     end else begin
                        rest_en = 1'b1;
                     end
                  end
                  mel_next_in = (({1'b0, step} + 4'd1) >= StepsCount) ? 3'd0 : step + 3'd1;
               end
               // one cue step
               if (cue_active_ff) begin
                  if (cue_total_ff == 8'd0) begin
                     stop = 1'b1;
                  end else if (cue_step_ff != 8'd0) begin
                     cue_step_in  = cue_step_ff - 8'd1;
                     cue_total_in = cue_total_ff - 8'd1;
                  end else if (!cue_started_ff) begin
                     tone_en        = 1'b1;
                     tone_cue       = 1'b1;
                     tone_note      = cue_note_ff;
                     cue_step_in    = cue_total_ff;
                     cue_started_in = 1'b1;
                  end else begin
                     stop = 1'b1;
                  end
                  // hand the speaker back to the melody
                  if (stop) begin
                     cue_active_in  = 1'b0;
                     cue_note_in    = NOTE_C4;
                     cue_started_in = 1'b0;
                     cue_step_in    = 8'd0;
                     cue_total_in   = 8'd0;
                     rest_en        = 1'b1;
                     if (audio_mode_ff != MODE_SILENT) begin
                        if (mel_valid_in && (mel_left_in != 9'd0)) begin
                           if (mel_is_tone(mel_cur_in)) begin
                              tone_en   = 1'b1;
                              tone_note = mel_note(mel_cur_in);
                           end
                        end else begin
                           mel_left_in = 9'd0;
                        end
                     end
                  end
               end
            end
         end
         OP_BUTTON: begin
            cue_active_in  = 1'b1;
            cue_started_in = 1'b0;
            cue_step_in    = 8'd0;
            cue_total_in   = PRESS_TIME;
            unique case (req_data.button_number)
               BTN_C5:  cue_note_in = NOTE_C5;
               BTN_G4:  cue_note_in = NOTE_G4;
               BTN_DS4: cue_note_in = NOTE_DSHARP4;
               default: cue_note_in = NOTE_C4;
            endcase
         end
         OP_BEEP: begin
            cue_active_in  = 1'b1;
            cue_started_in = 1'b0;
            cue_step_in    = 8'd0;
            cue_total_in   = BEEP_TIME;
            cue_note_in    = NOTE_B3;
         end
         default: begin
            // restart: melody state only, PWM registers keep their values
            mel_next_in  = 3'd0;
            mel_cur_in   = 3'd0;
            mel_left_in  = 9'd0;
            mel_valid_in = 1'b0;
         end
      endcase
   end

   // Tone writer: period lookup, then compare = period / divisor, at least 1; a rest sets compare to 0.
   always_comb begin
      unique case (tone_note)
         NOTE_DSHARP4: tone_period = period_ds4_ff;
         NOTE_G4:      tone_period = period_g4_ff;
         NOTE_C5:      tone_period = period_c5_ff;
         NOTE_B3:      tone_period = period_b3_ff;
         default:      tone_period = period_c4_ff;
      endcase
      if (tone_cue) begin
         recip = RecipButton;
      end else if (audio_mode_ff == MODE_SOFT) begin
         recip = RecipSoft;
      end else begin
         recip = RecipNormal;
      end
      product  = {{RecipW{1'b0}}, tone_period} * {8'd0, recip};
      quotient = product[RecipShift +: 8];
      period_in  = period_ff;
      compare_in = compare_ff;
      if (tone_en) begin
         period_in  = tone_period;
         compare_in = (quotient == 8'd0) ? 8'd1 : quotient;
      end else if (rest_en) begin
         compare_in = 8'd0;
      end
   end

   assign result = '{pwm_period: period_in, pwm_compare: compare_in,
                     cue_playing: cue_active_in};

   // state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         audio_mode_ff  <= MODE_NORMAL;
         period_c4_ff   <= RST_PERIOD_C4;
         period_ds4_ff  <= RST_PERIOD_DS4;
         period_g4_ff   <= RST_PERIOD_G4;
         period_c5_ff   <= RST_PERIOD_C5;
         period_b3_ff   <= RST_PERIOD_B3;
         mel_next_ff    <= 3'd0;
         mel_cur_ff     <= 3'd0;
         mel_left_ff    <= 9'd0;
         mel_valid_ff   <= 1'b0;
         cue_active_ff  <= 1'b0;
         cue_note_ff    <= NOTE_C4;
         cue_started_ff <= 1'b0;
         cue_step_ff    <= 8'd0;
         cue_total_ff   <= 8'd0;
         period_ff      <= 8'd0;
         compare_ff     <= 8'd0;
         count_ff       <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_AUDIO_MODE: audio_mode_ff <= csr_data[1:0];
               CSR_PERIOD_C4:  period_c4_ff  <= csr_data;
               CSR_PERIOD_DS4: period_ds4_ff <= csr_data;
               CSR_PERIOD_G4:  period_g4_ff  <= csr_data;
               CSR_PERIOD_C5:  period_c5_ff  <= csr_data;
               CSR_PERIOD_B3:  period_b3_ff  <= csr_data;
               default: ;
            endcase
         end
         if (req_fire) begin
            mel_next_ff    <= mel_next_in;
            mel_cur_ff     <= mel_cur_in;
            mel_left_ff    <= mel_left_in;
            mel_valid_ff   <= mel_valid_in;
            cue_active_ff  <= cue_active_in;
            cue_note_ff    <= cue_note_in;
            cue_started_ff <= cue_started_in;
            cue_step_ff    <= cue_step_in;
            cue_total_ff   <= cue_total_in;
            period_ff      <= period_in;
            compare_ff     <= compare_in;
         end
         count_ff <= count_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
      end
   end

   // response buffer payload: head is shown, tail holds a second waiting response
   always_ff @(posedge clock) begin
      if (req_fire && ((count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_fire))) begin
         head_ff <= result;
      end else if (rsp_fire && (count_ff == 2'd2)) begin
         head_ff <= tail_ff;
      end
      if (req_fire && (count_ff == 2'd1) && !rsp_fire) begin
         tail_ff <= result;
      end
   end

   // an idle cue carries no timing
   a_cue_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !cue_active_ff |-> (!cue_started_ff && (cue_total_ff == 8'd0)
                          && (cue_step_ff == 8'd0)))
      else $error("idle cue holds timing");

   // the note's remaining time never exceeds the cue's remaining time
   a_cue_step_bound: assert property (@(posedge clock) disable iff (reset)
      cue_step_ff <= cue_total_ff)
      else $error("cue step time exceeds total");

   // the step pointer stays inside the melody
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, mel_next_ff} < StepsCount) && ({1'b0, mel_cur_ff} < StepsCount))
      else $error("melody step out of range");

   // the buffer never overfills
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("response buffer overflow");

   // a response is pending on the cycle after an accepted request
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted request produced no response");

endmodule
